>>> src/fbo_pkg.sv
// Shared types, codes and helpers for the float binary operation unit.
package fbo_pkg;

    localparam int FRAC_S = 23;
    localparam int BIAS_S = 127;
    localparam int FRAC_D = 52;
    localparam int BIAS_D = 1023;

    localparam int EW     = 14;
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef logic signed [EW-1:0] t_exp;

    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_MUL = 4'd2;
    localparam logic [3:0] FN_DIV = 4'd3;
    localparam logic [3:0] FN_EQ  = 4'd4;
    localparam logic [3:0] FN_NE  = 4'd5;
    localparam logic [3:0] FN_LT  = 4'd6;
    localparam logic [3:0] FN_LE  = 4'd7;
    localparam logic [3:0] FN_GT  = 4'd8;
    localparam logic [3:0] FN_GE  = 4'd9;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_OPERAND   = 3'd1;
    localparam logic [2:0] ERR_NONFINITE = 3'd2;
    localparam logic [2:0] ERR_ZERODIV   = 3'd3;
    localparam logic [2:0] ERR_OPERATION = 3'd4;

    typedef struct packed {
        logic [3:0]  func;
        logic        is_double;
        logic [63:0] left_operand;
        logic [63:0] right_operand;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_bits;
        logic [2:0]  error_code;
    } t_out_item;

    typedef enum logic [1:0] {K_DONE, K_ADD, K_MUL, K_DIV} t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        dbl;
        logic        neg_a;
        logic        neg_b;
        logic [52:0] mant_a;
        logic [52:0] mant_b;
        t_exp        scale_a;
        t_exp        scale_b;
        t_out_item   res;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_ALIGN, S_ADD_SUM, S_MUL_PROD, S_MUL_ACC,
        S_DIV_NORM, S_DIV_STEP, S_NORM, S_RND_SHIFT, S_RND_PACK
    } t_bstate;

    function automatic logic [63:0] signed_zero(input logic neg, input logic dbl);
        return dbl ? {neg, 63'b0} : {32'b0, neg, 31'b0};
    endfunction

endpackage

>>> src/fbo_front.sv
// Front end: operand checks, comparisons, unpacking and job classification.
module fbo_front (
    input  fbo_pkg::t_in_item i_item,
    output fbo_pkg::t_job     o_job
);

    typedef struct packed {
        logic        neg;
        logic [52:0] mant;
        fbo_pkg::t_exp scale;
    } t_unp;

    function automatic t_unp unpack_op(input logic [63:0] b, input logic dbl);
        t_unp        u;
        logic [10:0] ef;
        logic [10:0] ef_eff;
        if (dbl) begin
            ef     = b[62:52];
            u.neg  = b[63];
            u.mant = {(ef != 11'd0), b[51:0]};
        end else begin
            ef     = {3'b0, b[30:23]};
            u.neg  = b[31];
            u.mant = {29'b0, (ef != 11'd0), b[22:0]};
        end
        ef_eff  = (ef != 11'd0) ? ef : 11'd1;
        u.scale = fbo_pkg::t_exp'({3'b0, ef_eff})
                - (dbl ? fbo_pkg::t_exp'(fbo_pkg::BIAS_D + fbo_pkg::FRAC_D)
                       : fbo_pkg::t_exp'(fbo_pkg::BIAS_S + fbo_pkg::FRAC_S));
        return u;
    endfunction

    logic        dbl;
    logic [63:0] l, r;
    logic [62:0] ml, mr;
    logic        bad, both_zero, lt_mag, gt_mag, less, greater, eqv, nb_eff;
    t_unp        ua, ub;

    always_comb begin
        dbl = i_item.is_double;
        l   = i_item.left_operand;
        r   = i_item.right_operand;
        ml  = dbl ? l[62:0] : {32'b0, l[30:0]};
        mr  = dbl ? r[62:0] : {32'b0, r[30:0]};
        bad = (!dbl && ((|l[63:32]) || (|r[63:32])))
            || (dbl ? (&l[62:52]) : (&l[30:23]))
            || (dbl ? (&r[62:52]) : (&r[30:23]));
        ua  = unpack_op(l, dbl);
        ub  = unpack_op(r, dbl);

        both_zero = (ml == 63'd0) && (mr == 63'd0);
        lt_mag    = ml < mr;
        gt_mag    = ml > mr;
        less      = !both_zero && ((ua.neg != ub.neg) ? ua.neg : (ua.neg ? gt_mag : lt_mag));
        greater   = !both_zero && ((ua.neg != ub.neg) ? ub.neg : (ua.neg ? lt_mag : gt_mag));
        eqv       = !less && !greater;
        nb_eff    = ub.neg ^ (i_item.func == fbo_pkg::FN_SUB);

        o_job                = '0;
        o_job.kind           = fbo_pkg::K_DONE;
        o_job.dbl            = dbl;
        o_job.neg_a          = ua.neg;
        o_job.neg_b          = ub.neg;
        o_job.mant_a         = ua.mant;
        o_job.mant_b         = ub.mant;
        o_job.scale_a        = ua.scale;
        o_job.scale_b        = ub.scale;
        o_job.res.error_code = fbo_pkg::ERR_OK;

        if (bad) begin
            o_job.res.error_code = fbo_pkg::ERR_OPERAND;
        end else begin
            unique case (i_item.func) inside
                fbo_pkg::FN_ADD, fbo_pkg::FN_SUB: begin
                    o_job.kind = fbo_pkg::K_ADD;
                    // larger magnitude goes first
                    if (lt_mag) begin
                        o_job.neg_a   = nb_eff;
                        o_job.neg_b   = ua.neg;
                        o_job.mant_a  = ub.mant;
                        o_job.mant_b  = ua.mant;
                        o_job.scale_a = ub.scale;
                        o_job.scale_b = ua.scale;
                    end else begin
                        o_job.neg_b = nb_eff;
                    end
                end
                fbo_pkg::FN_MUL: begin
                    if (ua.mant == 53'd0 || ub.mant == 53'd0) begin
                        o_job.res.result_bits = fbo_pkg::signed_zero(ua.neg ^ ub.neg, dbl);
                    end else begin
                        o_job.kind = fbo_pkg::K_MUL;
                    end
                end
                fbo_pkg::FN_DIV: begin
                    if (ub.mant == 53'd0) begin
                        o_job.res.error_code = fbo_pkg::ERR_ZERODIV;
                    end else if (ua.mant == 53'd0) begin
                        o_job.res.result_bits = fbo_pkg::signed_zero(ua.neg ^ ub.neg, dbl);
                    end else begin
                        o_job.kind = fbo_pkg::K_DIV;
                    end
                end
                fbo_pkg::FN_EQ: o_job.res.result_bits = {63'b0, eqv};
                fbo_pkg::FN_NE: o_job.res.result_bits = {63'b0, !eqv};
                fbo_pkg::FN_LT: o_job.res.result_bits = {63'b0, less};
                fbo_pkg::FN_LE: o_job.res.result_bits = {63'b0, !greater};
                fbo_pkg::FN_GT: o_job.res.result_bits = {63'b0, greater};
                fbo_pkg::FN_GE: o_job.res.result_bits = {63'b0, !less};
                default: o_job.res.error_code = fbo_pkg::ERR_OPERATION;
            endcase
        end
    end

endmodule

>>> src/fbo_queue.sv
// Two-entry job queue between front end and execution back end.
module fbo_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fbo_pkg::t_job   i_job,
    input  logic            i_pop,
    output fbo_pkg::t_job   o_job,
    output fbo_pkg::t_qstat o_stat
);

    fbo_pkg::t_job            r_mem [fbo_pkg::QDEPTH];
    logic [fbo_pkg::QAW-1:0]  r_wr, r_rd;
    logic [fbo_pkg::QAW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (fbo_pkg::QAW+1)'(i_push) - (fbo_pkg::QAW+1)'(i_pop);
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_count == (fbo_pkg::QAW+1)'(fbo_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

>>> src/fbo_back.sv
// Back end: sequenced add, multiply, divide, normalise and round.
module fbo_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbo_pkg::t_job      i_job,
    input  logic               i_avail,
    output logic               o_pop,
    output logic               o_done,
    output fbo_pkg::t_out_item o_result
);

    // leading-zero step for a normalise pass: 16, 4, 1 or done
    function automatic logic [4:0] lz_step(input logic [15:0] top);
        if (top == 16'd0)           return 5'd16;
        else if (top[15:12] == 4'd0) return 5'd4;
        else if (!top[15])          return 5'd1;
        else                        return 5'd0;
    endfunction

    fbo_pkg::t_bstate   r_state, n_state;
    logic               r_dbl, n_dbl;
    logic               r_na, n_na, r_nb, n_nb, r_neg, n_neg;
    logic [52:0]        r_ma, n_ma, r_mb, n_mb;
    fbo_pkg::t_exp      r_sa, n_sa, r_sb, n_sb, r_exp, n_exp, r_e, n_e;
    logic [105:0]       r_acc, n_acc;
    logic               r_sticky, n_sticky;
    logic [61:0]        r_yb, n_yb;
    logic [63:0]        r_prod, n_prod;
    logic [1:0]         r_step, n_step;
    logic [5:0]         r_cnt, n_cnt;
    logic [53:0]        r_rem, n_rem;
    logic [62:0]        r_q, n_q;
    logic [52:0]        r_rq, n_rq;
    logic               r_up, n_up, r_ovf, n_ovf;
    fbo_pkg::t_out_item r_res, n_res;
    logic               r_done, n_done;

    // combinational temporaries
    logic [61:0]   xa62, xb62;
    logic [62:0]   sum;
    fbo_pkg::t_exp d, e, lowe, emax, shift, biasv, fracv;
    logic [5:0]    sh6;
    logic [62:0]   mant, mask63, remv, half, qv;
    logic          stk;
    logic [31:0]   mx, my;
    logic [105:0]  addend;
    logic [4:0]    ka, kb;
    logic          ge;
    logic [53:0]   diff, qq;
    logic [62:0]   nq;
    logic          top_ovf, normal;
    fbo_pkg::t_exp e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbo_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dbl    <= n_dbl;
        r_na     <= n_na;
        r_nb     <= n_nb;
        r_neg    <= n_neg;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_sa     <= n_sa;
        r_sb     <= n_sb;
        r_exp    <= n_exp;
        r_e      <= n_e;
        r_acc    <= n_acc;
        r_sticky <= n_sticky;
        r_yb     <= n_yb;
        r_prod   <= n_prod;
        r_step   <= n_step;
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_rq     <= n_rq;
        r_up     <= n_up;
        r_ovf    <= n_ovf;
        r_res    <= n_res;
    end

    always_comb begin
        n_state = r_state;  n_dbl = r_dbl;  n_na = r_na;  n_nb = r_nb;  n_neg = r_neg;
        n_ma = r_ma;  n_mb = r_mb;  n_sa = r_sa;  n_sb = r_sb;  n_exp = r_exp;  n_e = r_e;
        n_acc = r_acc;  n_sticky = r_sticky;  n_yb = r_yb;  n_prod = r_prod;
        n_step = r_step;  n_cnt = r_cnt;  n_rem = r_rem;  n_q = r_q;  n_rq = r_rq;
        n_up = r_up;  n_ovf = r_ovf;  n_res = r_res;  n_done = 1'b0;  o_pop = 1'b0;

        xa62   = {r_ma, 9'b0};
        xb62   = {r_mb, 9'b0};
        d      = r_sa - r_sb;
        sum    = '0;
        biasv  = r_dbl ? fbo_pkg::t_exp'(fbo_pkg::BIAS_D) : fbo_pkg::t_exp'(fbo_pkg::BIAS_S);
        fracv  = r_dbl ? fbo_pkg::t_exp'(fbo_pkg::FRAC_D) : fbo_pkg::t_exp'(fbo_pkg::FRAC_S);
        lowe   = fbo_pkg::t_exp'(1) - biasv;
        mant   = r_acc[105:43];
        stk    = r_sticky | (|r_acc[42:0]);
        e      = r_exp + fbo_pkg::t_exp'(62);
        emax   = (e > lowe) ? e : lowe;
        shift  = emax - fracv - r_exp;
        sh6    = shift[5:0];
        mask63 = ~({63{1'b1}} << sh6);
        remv   = mant & mask63;
        half   = 63'd1 << (sh6 - 6'd1);
        qv     = mant >> sh6;
        mx     = '0;
        my     = '0;
        addend = '0;
        ka     = lz_step(r_ma[52:37]);
        kb     = lz_step(r_mb[52:37]);
        ge     = r_rem >= {1'b0, r_mb};
        diff   = ge ? (r_rem - {1'b0, r_mb}) : r_rem;
        nq     = {r_q[61:0], ge};
        qq     = {1'b0, r_rq} + {53'b0, r_up};
        top_ovf = r_dbl ? (qq == (54'd1 << 53)) : (qq == (54'd1 << 24));
        e2     = r_e;
        normal = 1'b0;

        unique case (r_state)
            fbo_pkg::S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    n_dbl = i_job.dbl;
                    n_na  = i_job.neg_a;
                    n_nb  = i_job.neg_b;
                    n_neg = i_job.neg_a ^ i_job.neg_b;
                    n_ma  = i_job.mant_a;
                    n_mb  = i_job.mant_b;
                    n_sa  = i_job.scale_a;
                    n_sb  = i_job.scale_b;
                    n_sticky = 1'b0;
                    unique case (i_job.kind)
                        fbo_pkg::K_DONE: begin
                            n_res  = i_job.res;
                            n_done = 1'b1;
                        end
                        fbo_pkg::K_ADD: n_state = fbo_pkg::S_ADD_ALIGN;
                        fbo_pkg::K_MUL: begin
                            n_acc   = '0;
                            n_step  = 2'd0;
                            n_exp   = i_job.scale_a + i_job.scale_b + fbo_pkg::t_exp'(43);
                            n_state = fbo_pkg::S_MUL_PROD;
                        end
                        default: begin
                            n_exp   = i_job.scale_a - i_job.scale_b - fbo_pkg::t_exp'(62);
                            n_state = fbo_pkg::S_DIV_NORM;
                        end
                    endcase
                end
            end
            fbo_pkg::S_ADD_ALIGN: begin
                if (d < 0) d = '0;
                if (d > fbo_pkg::t_exp'(63)) begin
                    n_yb     = '0;
                    n_sticky = (xb62 != 62'd0);
                end else begin
                    n_yb     = xb62 >> d[5:0];
                    n_sticky = |(xb62 & ~({62{1'b1}} << d[5:0]));
                end
                n_state = fbo_pkg::S_ADD_SUM;
            end
            fbo_pkg::S_ADD_SUM: begin
                if (r_na == r_nb) sum = {1'b0, xa62} + {1'b0, r_yb};
                else sum = {1'b0, xa62} - {1'b0, r_yb} - {62'b0, r_sticky};
                if (r_na != r_nb && sum == 63'd0 && !r_sticky) begin
                    n_res   = '{result_bits: 64'd0, error_code: fbo_pkg::ERR_OK};
                    n_done  = 1'b1;
                    n_state = fbo_pkg::S_IDLE;
                end else if (sum == 63'd0) begin
                    n_res   = '{result_bits: fbo_pkg::signed_zero(r_na, r_dbl),
                                error_code: fbo_pkg::ERR_OK};
                    n_done  = 1'b1;
                    n_state = fbo_pkg::S_IDLE;
                end else begin
                    n_acc   = {sum, 43'b0};
                    n_exp   = r_sa - fbo_pkg::t_exp'(9);
                    n_neg   = r_na;
                    n_state = fbo_pkg::S_NORM;
                end
            end
            fbo_pkg::S_MUL_PROD: begin
                case (r_step)
                    2'd0: begin mx = r_ma[31:0];          my = r_mb[31:0];          end
                    2'd1: begin mx = r_ma[31:0];          my = {11'b0, r_mb[52:32]}; end
                    2'd2: begin mx = {11'b0, r_ma[52:32]}; my = r_mb[31:0];          end
                    default: begin mx = {11'b0, r_ma[52:32]}; my = {11'b0, r_mb[52:32]}; end
                endcase
                n_prod  = mx * my;
                n_state = fbo_pkg::S_MUL_ACC;
            end
            fbo_pkg::S_MUL_ACC: begin
                case (r_step)
                    2'd0:    addend = {42'b0, r_prod};
                    2'd3:    addend = {r_prod[41:0], 64'b0};
                    default: addend = {10'b0, r_prod, 32'b0};
                endcase
                n_acc = r_acc + addend;
                if (r_step == 2'd3) begin
                    n_state = fbo_pkg::S_NORM;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = fbo_pkg::S_MUL_PROD;
                end
            end
            fbo_pkg::S_DIV_NORM: begin
                n_ma  = r_ma << ka;
                n_mb  = r_mb << kb;
                n_exp = r_exp - fbo_pkg::t_exp'({9'b0, ka}) + fbo_pkg::t_exp'({9'b0, kb});
                if (r_ma[52] && r_mb[52]) begin
                    n_rem   = {1'b0, r_ma};
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = fbo_pkg::S_DIV_STEP;
                end
            end
            fbo_pkg::S_DIV_STEP: begin
                n_rem = {diff[52:0], 1'b0};
                n_q   = nq;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd62) begin
                    n_acc    = {nq, 43'b0};
                    n_sticky = ({diff[52:0], 1'b0} != 54'd0);
                    n_state  = fbo_pkg::S_NORM;
                end
            end
            fbo_pkg::S_NORM: begin
                if (r_acc[105]) begin
                    n_state = fbo_pkg::S_RND_SHIFT;
                end else begin
                    n_acc = r_acc << lz_step(r_acc[105:90]);
                    n_exp = r_exp - fbo_pkg::t_exp'({9'b0, lz_step(r_acc[105:90])});
                end
            end
            fbo_pkg::S_RND_SHIFT: begin
                n_e   = e;
                n_ovf = e > biasv;
                if (shift > fbo_pkg::t_exp'(63)) begin
                    n_rq = '0;
                    n_up = 1'b0;
                end else begin
                    n_rq = qv[52:0];
                    n_up = (remv > half) || (remv == half && (stk || qv[0]));
                end
                n_state = fbo_pkg::S_RND_PACK;
            end
            fbo_pkg::S_RND_PACK: begin
                if (top_ovf) begin
                    qq = qq >> 1;
                    e2 = r_e + fbo_pkg::t_exp'(1);
                end
                normal = r_dbl ? qq[52] : qq[23];
                emax   = normal ? (((e2 > lowe) ? e2 : lowe) + biasv) : '0;
                n_res.error_code = fbo_pkg::ERR_OK;
                if (r_ovf) begin
                    n_res = '{result_bits: 64'd0, error_code: fbo_pkg::ERR_NONFINITE};
                end else if ({1'b0, r_rq} + {53'b0, r_up} == 54'd0) begin
                    n_res.result_bits = fbo_pkg::signed_zero(r_neg, r_dbl);
                end else if (e2 > biasv) begin
                    n_res = '{result_bits: 64'd0, error_code: fbo_pkg::ERR_NONFINITE};
                end else if (r_dbl) begin
                    n_res.result_bits = {r_neg, emax[10:0], qq[51:0]};
                end else begin
                    n_res.result_bits = {32'b0, r_neg, emax[7:0], qq[22:0]};
                end
                n_done  = 1'b1;
                n_state = fbo_pkg::S_IDLE;
            end
            default: n_state = fbo_pkg::S_IDLE;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == fbo_pkg::S_IDLE)
        else $error("result strobe outside idle");
    a_div_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fbo_pkg::S_DIV_STEP |-> r_mb[52])
        else $error("divisor not normalised");
    a_norm_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fbo_pkg::S_NORM |-> r_acc != 106'd0)
        else $error("normalising a zero value");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.error_code != fbo_pkg::ERR_OK) |-> o_result.result_bits == 64'd0)
        else $error("error result carries data");

endmodule

>>> src/ieee_float_binary_op_unit_top.sv
// Top level of the float binary operation unit: front end, job queue, back end.
//   channel  | handshake          | payload
//   input    | start / busy       | i_item  (func, is_double, left/right operand)
//   result   | o_done strobe      | o_result (result_bits, error_code)
// An item is taken when start is high and busy low; busy rises while the
// two-entry queue is full. Compares and early-out cases finish in the idle state,
// a zero sum in the add stages; add and multiply go on through normalise and
// round; divide, the longest in either precision, runs the one-bit-per-cycle
// restoring divider (63 steps) plus normalise and round.
// Synchronous active-low reset empties the queue; results cannot be stalled.
module ieee_float_binary_op_unit_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  fbo_pkg::t_in_item  i_item,
    output logic               o_done,
    output fbo_pkg::t_out_item o_result
);

    fbo_pkg::t_job   job_in, job_out;
    fbo_pkg::t_qstat qstat;
    logic            pop;

    fbo_front u_front (
        .i_item (i_item),
        .o_job  (job_in)
    );

    fbo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !qstat.full),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_stat  (qstat)
    );

    fbo_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (job_out),
        .i_avail  (!qstat.empty),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

    assign busy = qstat.full;

endmodule

>>> dv/tb_ieee_float_binary_op_unit_top.sv
// Self-checking testbench for the float binary operation unit: directed table plus random items.
`timescale 1ns / 100ps

module tb_ieee_float_binary_op_unit_top;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int N_RANDOM    = 1930;

    typedef struct {
        fbo_pkg::t_in_item  item;
        bit                 typed;
        fbo_pkg::t_out_item res;
    } t_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    fbo_pkg::t_in_item  i_item  = '0;
    logic               o_done;
    fbo_pkg::t_out_item o_result;

    fbo_pkg::t_out_item pending_results[$];
    t_row               dir_rows[$];
    int        n_errors   = 0;
    int        n_sent     = 0;
    int        n_checked  = 0;
    int        n_err_code = 0;
    int        n_cycles   = 0;

    ieee_float_binary_op_unit_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic logic [63:0] lmask(input int w);
        if (w <= 0) return 64'd0;
        if (w >= 64) return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic int top_bit(input logic [127:0] v);
        for (int i = 127; i >= 0; i--)
            if (v[i]) return i;
        return -1;
    endfunction

    function automatic void fp_unpack(input logic [63:0] bits, input int frac, input int expw,
                                      input int bias, output bit neg, output logic [63:0] mant,
                                      output int scale);
        logic [63:0] ef;
        ef    = (bits >> frac) & lmask(expw);
        neg   = bits[frac+expw];
        mant  = (bits & lmask(frac)) | ((ef != 0) ? (64'd1 << frac) : 64'd0);
        scale = ((ef != 0) ? int'(ef) : 1) - bias - frac;
    endfunction

    // mant has its top bit at 62; sticky means the value lies just above mant
    function automatic logic [2:0] fp_round_pack(input bit neg, input logic [63:0] mant,
                                                 input int exp2, input bit sticky,
                                                 input int frac, input int expw, input int bias,
                                                 output logic [63:0] res);
        logic [63:0] sgn, q, rem, half, stored;
        int e, lowe, sh;
        bit up;
        sgn  = neg ? (64'd1 << (frac + expw)) : 64'd0;
        e    = exp2 + 62;
        lowe = 1 - bias;
        sh   = ((e > lowe) ? e : lowe) - frac - exp2;
        q    = 0;
        up   = 0;
        res  = 0;
        if (e > bias) return fbo_pkg::ERR_NONFINITE;
        if (sh < 64) begin
            rem  = mant & lmask(sh);
            half = 64'd1 << (sh - 1);
            q    = mant >> sh;
            up   = (rem > half) || (rem == half && (sticky || q[0]));
        end
        if (up) q++;
        if (q == 0) begin
            res = sgn;
            return fbo_pkg::ERR_OK;
        end
        if (q == (64'd1 << (frac + 1))) begin
            q = q >> 1;
            e++;
        end
        if (e > bias) return fbo_pkg::ERR_NONFINITE;
        stored = (q >= (64'd1 << frac)) ? 64'(((e > lowe) ? e : lowe) + bias) : 64'd0;
        res = sgn | (stored << frac) | (q & lmask(frac));
        return fbo_pkg::ERR_OK;
    endfunction

    function automatic logic [2:0] fp_addsub(input bit sub, input logic [63:0] l, r,
                                             input int frac, input int expw, input int bias,
                                             output logic [63:0] res);
        logic [63:0] mm, ma, mb, tm, xa, xb, yb, s;
        bit na, nb, tn, sticky;
        int sa, sb, ts, d, p;
        mm = lmask(frac + expw);
        sticky = 0;
        res = 0;
        fp_unpack(l, frac, expw, bias, na, ma, sa);
        fp_unpack(r, frac, expw, bias, nb, mb, sb);
        if (sub) nb = !nb;
        if ((r & mm) > (l & mm)) begin
            tn = na; na = nb; nb = tn;
            tm = ma; ma = mb; mb = tm;
            ts = sa; sa = sb; sb = ts;
        end
        xa = ma << 9;
        xb = mb << 9;
        d  = sa - sb;
        if (d < 0) d = 0;
        if (d >= 64) begin
            yb = 0;
            sticky = (xb != 0);
        end else begin
            yb = xb >> d;
            sticky = ((xb & lmask(d)) != 0);
        end
        if (na == nb) begin
            s = xa + yb;
        end else begin
            s = xa - yb - (sticky ? 64'd1 : 64'd0);
            // exact cancellation is always +0
            if (s == 0 && !sticky) return fbo_pkg::ERR_OK;
        end
        if (s == 0) begin
            res = na ? (64'd1 << (frac + expw)) : 64'd0;
            return fbo_pkg::ERR_OK;
        end
        p = top_bit({64'd0, s});
        s = s << (62 - p);
        return fp_round_pack(na, s, sa - 9 - (62 - p), sticky, frac, expw, bias, res);
    endfunction

    function automatic logic [2:0] fp_mul(input logic [63:0] l, r,
                                          input int frac, input int expw, input int bias,
                                          output logic [63:0] res);
        logic [63:0] ma, mb, mant;
        logic [127:0] prod;
        bit na, nb, neg, sticky;
        int sa, sb, p, exp2, s;
        fp_unpack(l, frac, expw, bias, na, ma, sa);
        fp_unpack(r, frac, expw, bias, nb, mb, sb);
        neg = (na != nb);
        sticky = 0;
        res = 0;
        if (ma == 0 || mb == 0) begin
            res = neg ? (64'd1 << (frac + expw)) : 64'd0;
            return fbo_pkg::ERR_OK;
        end
        prod = 128'(ma) * 128'(mb);
        p    = top_bit(prod);
        exp2 = sa + sb;
        if (p > 62) begin
            s      = p - 62;
            mant   = 64'(prod >> s);
            sticky = ((prod & ((128'd1 << s) - 128'd1)) != 0);
            exp2  += s;
        end else begin
            mant  = prod[63:0] << (62 - p);
            exp2 -= 62 - p;
        end
        return fp_round_pack(neg, mant, exp2, sticky, frac, expw, bias, res);
    endfunction

    function automatic logic [2:0] fp_div(input logic [63:0] l, r,
                                          input int frac, input int expw, input int bias,
                                          output logic [63:0] res);
        logic [63:0] ma, mb, q, rem;
        bit na, nb, neg;
        int sa, sb, la, lb, exp2;
        fp_unpack(l, frac, expw, bias, na, ma, sa);
        fp_unpack(r, frac, expw, bias, nb, mb, sb);
        res = 0;
        q = 0;
        if (mb == 0) return fbo_pkg::ERR_ZERODIV;
        neg = (na != nb);
        if (ma == 0) begin
            res = neg ? (64'd1 << (frac + expw)) : 64'd0;
            return fbo_pkg::ERR_OK;
        end
        la = 52 - top_bit({64'd0, ma});
        lb = 52 - top_bit({64'd0, mb});
        ma = ma << la;
        mb = mb << lb;
        rem = ma;
        for (int i = 0; i < 63; i++) begin
            q = q << 1;
            if (rem >= mb) begin
                rem = rem - mb;
                q[0] = 1'b1;
            end
            rem = rem << 1;
        end
        exp2 = sa - la - sb + lb - 62;
        if (q < (64'd1 << 62)) begin
            q = q << 1;
            exp2--;
        end
        return fp_round_pack(neg, q, exp2, rem != 0, frac, expw, bias, res);
    endfunction

    function automatic fbo_pkg::t_out_item fp_binop(input fbo_pkg::t_in_item it);
        fbo_pkg::t_out_item o;
        int frac, expw, bias, order;
        logic [63:0] em, mm, l, r, ml, mr;
        bit nl, nr;
        frac  = it.is_double ? fbo_pkg::FRAC_D : fbo_pkg::FRAC_S;
        bias  = it.is_double ? fbo_pkg::BIAS_D : fbo_pkg::BIAS_S;
        expw  = it.is_double ? 11 : 8;
        em    = lmask(expw);
        l     = it.left_operand;
        r     = it.right_operand;
        o     = '0;
        if ((!it.is_double && (l[63:32] != 0 || r[63:32] != 0)) ||
            ((l >> frac) & em) == em || ((r >> frac) & em) == em) begin
            o.error_code = fbo_pkg::ERR_OPERAND;
        end else begin
            case (it.func)
                fbo_pkg::FN_EQ, fbo_pkg::FN_NE, fbo_pkg::FN_LT,
                fbo_pkg::FN_LE, fbo_pkg::FN_GT, fbo_pkg::FN_GE: begin
                    mm = lmask(frac + expw);
                    ml = l & mm;
                    mr = r & mm;
                    nl = l[frac+expw];
                    nr = r[frac+expw];
                    if (ml == 0 && mr == 0) order = 0;
                    else if (nl != nr) order = nl ? -1 : 1;
                    else begin
                        order = (ml < mr) ? -1 : ((ml > mr) ? 1 : 0);
                        if (nl) order = -order;
                    end
                    case (it.func)
                        fbo_pkg::FN_EQ: o.result_bits = 64'(order == 0);
                        fbo_pkg::FN_NE: o.result_bits = 64'(order != 0);
                        fbo_pkg::FN_LT: o.result_bits = 64'(order < 0);
                        fbo_pkg::FN_LE: o.result_bits = 64'(order <= 0);
                        fbo_pkg::FN_GT: o.result_bits = 64'(order > 0);
                        default:        o.result_bits = 64'(order >= 0);
                    endcase
                end
                fbo_pkg::FN_ADD, fbo_pkg::FN_SUB:
                    o.error_code = fp_addsub(it.func == fbo_pkg::FN_SUB, l, r, frac, expw, bias,
                                             o.result_bits);
                fbo_pkg::FN_MUL:
                    o.error_code = fp_mul(l, r, frac, expw, bias, o.result_bits);
                fbo_pkg::FN_DIV:
                    o.error_code = fp_div(l, r, frac, expw, bias, o.result_bits);
                default: o.error_code = fbo_pkg::ERR_OPERATION;
            endcase
        end
        if (o.error_code != fbo_pkg::ERR_OK) o.result_bits = '0;
        return o;
    endfunction

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        fbo_pkg::t_out_item want;
        n_cycles <= n_cycles + 1;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: bits %h err %0d",
                       o_result.result_bits, o_result.error_code);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (want.error_code != fbo_pkg::ERR_OK) n_err_code++;
                if (o_result.result_bits !== want.result_bits) begin
                    $error("result_bits: expected %h, got %h", want.result_bits,
                           o_result.result_bits);
                    n_errors++;
                end
                if (o_result.error_code !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d", want.error_code,
                           o_result.error_code);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("tb_ieee_float_binary_op_unit_top: done, errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    // holds start high until the item is taken; start is left high for the caller
    task automatic send_item(input fbo_pkg::t_in_item it, input bit typed,
                             input fbo_pkg::t_out_item res);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results = {pending_results, (typed ? res : fp_binop(it))};
        n_sent++;
    endtask

    task automatic idle_gap(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic void add_row(input logic [3:0] fn, input bit dbl,
                                    input logic [63:0] l, r, input bit typed,
                                    input logic [63:0] bits, input logic [2:0] err);
        t_row row;
        row.item.func          = fn;
        row.item.is_double     = dbl;
        row.item.left_operand  = l;
        row.item.right_operand = r;
        row.typed              = typed;
        row.res.result_bits    = bits;
        row.res.error_code     = err;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic logic [63:0] rand_operand(input bit dbl);
        logic [63:0] v;
        int frac, expw, bias;
        frac = dbl ? fbo_pkg::FRAC_D : fbo_pkg::FRAC_S;
        expw = dbl ? 11 : 8;
        bias = dbl ? fbo_pkg::BIAS_D : fbo_pkg::BIAS_S;
        v = {$urandom, $urandom} & lmask(frac);
        case ($urandom_range(0, 19))
            0:       v = 0;
            1, 2:    ;  // subnormal
            3:       v |= 64'(lmask(expw) - 64'($urandom_range(1, 3))) << frac;
            4:       v |= 64'($urandom_range(1, 3)) << frac;
            5:       v = {$urandom, $urandom};  // anything, incl. non-finite and junk
            6:       v |= lmask(expw) << frac;  // infinity or NaN
            default: v |= 64'(bias + $urandom_range(0, 60) - 30) << frac;
        endcase
        if (v != 0 || $urandom_range(0, 1)) v[frac+expw] = 1'($urandom_range(0, 1));
        if (!dbl && $urandom_range(0, 99) != 0) v[63:32] = 0;
        return v;
    endfunction

    task automatic send_random(input int pct);
        fbo_pkg::t_in_item it;
        it.func          = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                        : 4'($urandom_range(0, 9));
        it.is_double     = 1'($urandom_range(0, 1));
        it.left_operand  = rand_operand(it.is_double);
        case ($urandom_range(0, 7))
            0:       it.right_operand = it.left_operand;
            1:       it.right_operand = it.left_operand ^ (it.is_double ? 64'h8000_0000_0000_0001
                                                                        : 64'h8000_0001);
            default: it.right_operand = rand_operand(it.is_double);
        endcase
        send_item(it, 1'b0, '0);
        idle_gap(pct);
    endtask

    initial begin
        add_row(fbo_pkg::FN_ADD, 1, 64'h3FF0000000000000, 64'h3FF0000000000000, 1,
                64'h4000000000000000, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_SUB, 1, 64'h3FF0000000000000, 64'h3FF0000000000000, 1,
                64'h0, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_EQ,  0, 64'h0, 64'h80000000, 1, 64'h1, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_NE,  0, 64'h0, 64'h80000000, 1, 64'h0, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_LT,  1, 64'hBFF0000000000000, 64'h3FF0000000000000, 1,
                64'h1, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_GE,  0, 64'h3F800000, 64'h3F800000, 1, 64'h1, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_LE,  1, 64'h8000000000000000, 64'h0, 1, 64'h1, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_GT,  0, 64'h7F7FFFFF, 64'h00000001, 1, 64'h1, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_DIV, 1, 64'h3FF0000000000000, 64'h0, 1, 64'h0,
                fbo_pkg::ERR_ZERODIV);
        add_row(fbo_pkg::FN_DIV, 0, 64'h0, 64'h80000000, 1, 64'h0, fbo_pkg::ERR_ZERODIV);
        add_row(fbo_pkg::FN_ADD, 0, 64'h7F800000, 64'h3F800000, 1, 64'h0,
                fbo_pkg::ERR_OPERAND);
        add_row(fbo_pkg::FN_MUL, 1, 64'h3FF0000000000000, 64'h7FF8000000000000, 1, 64'h0,
                fbo_pkg::ERR_OPERAND);
        add_row(fbo_pkg::FN_ADD, 0, 64'hFFFFFFFF_3F800000, 64'h3F800000, 1, 64'h0,
                fbo_pkg::ERR_OPERAND);
        add_row(4'd15, 1, 64'hFFEFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 1, 64'h0,
                fbo_pkg::ERR_OPERATION);
        add_row(4'd10, 0, 64'h0, 64'h0, 1, 64'h0, fbo_pkg::ERR_OPERATION);
        add_row(fbo_pkg::FN_MUL, 1, 64'h7FEFFFFFFFFFFFFF, 64'h4000000000000000, 1, 64'h0,
                fbo_pkg::ERR_NONFINITE);
        add_row(fbo_pkg::FN_ADD, 0, 64'h7F7FFFFF, 64'h7F7FFFFF, 1, 64'h0,
                fbo_pkg::ERR_NONFINITE);
        // half of the smallest subnormal ties to even, i.e. to zero
        add_row(fbo_pkg::FN_MUL, 1, 64'h1, 64'h3FE0000000000000, 1, 64'h0, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_MUL, 0, 64'h80000001, 64'h3E800000, 1, 64'h80000000,
                fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_ADD, 1, 64'h8000000000000000, 64'h8000000000000000, 1,
                64'h8000000000000000, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_DIV, 1, 64'h7FEFFFFFFFFFFFFF, 64'h1, 0, 64'h0, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_ADD, 1, 64'h1, 64'h800FFFFFFFFFFFFF, 0, 64'h0, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_SUB, 0, 64'h3F800000, 64'h00000001, 0, 64'h0, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_DIV, 0, 64'h3F800000, 64'h40400000, 0, 64'h0, fbo_pkg::ERR_OK);
        add_row(fbo_pkg::FN_MUL, 1, 64'hFFEFFFFFFFFFFFFF, 64'h000FFFFFFFFFFFFF, 0, 64'h0,
                fbo_pkg::ERR_OK);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);
            idle_gap(17);
        end
        for (int n = 0; n < N_RANDOM / 3; n++) send_random(17);

        // drain completely before carrying on
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM / 3; n++) send_random(56);
        for (int n = 0; n < N_RANDOM - 2 * (N_RANDOM / 3); n++) send_random(0);
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("sent %0d items (%0d from the table), checked %0d results, %0d with an error code",
                 n_sent, dir_rows.size(), n_checked, n_err_code);
        $display("covered both precisions, all ops, signed zeros, subnormals and error paths");
        if (n_errors == 0 && pending_results.size() == 0)
            $display("tb_ieee_float_binary_op_unit_top: done, clean");
        else
            $display("tb_ieee_float_binary_op_unit_top: done, errors");
        $finish;
    end

endmodule
